FILE: rtl/simplex_noise_2d_assert.svh
// Assertion macros shared by the simplex noise block.
// Each macro checks an implication on every rising clock edge outside reset.
`ifndef SIMPLEX_NOISE_2D_ASSERT_SVH
`define SIMPLEX_NOISE_2D_ASSERT_SVH
`ifndef SYNTH
`define SND_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("simplex_noise_2d: same-cycle check failed");
`define SND_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("simplex_noise_2d: next-cycle check failed");
`else
`define SND_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SND_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/snd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_pkg: shared definitions for the 2D simplex noise block
// Fixed-point constants, hash mixer constants and the corner record that
// travels from the cell stages to the corner pipelines.
// ----------------------------------------------------------------------------
package snd_pkg;

  // Skew factor F2 and the unskew factor G2, fixed point.
  localparam logic signed [15:0] SKEW_Q15    = 16'sd11994;
  localparam logic signed [15:0] UNSKEW2_Q16 = 16'sd13850;

  // Corner offsets in Q16.16: +G2, G2 - 1.0 and 2*G2 - 1.0.
  localparam logic signed [35:0] OFS_G1     = 36'sd13850;
  localparam logic signed [35:0] OFS_G1_M1  = -36'sd51686;
  localparam logic signed [35:0] OFS_G2_M1  = -36'sd37836;

  // Hash mixer constants.
  localparam logic [31:0] HASH_C0 = 32'h9E3779B9;
  localparam logic [31:0] HASH_C1 = 32'h85EBCA77;
  localparam logic [31:0] HASH_C2 = 32'hC2B2AE3D;
  localparam logic [31:0] HASH_C3 = 32'h27D4EB2F;

  // One corner as it enters its falloff pipeline.
  typedef struct packed {
    logic [31:0]        mix;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               near;
  } corner_in_t;

endpackage

FILE: rtl/simplex_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_noise_2d: 2D simplex noise, one sample per item
// Fixed-point skewed lattice, hashed gradients and a saturated Q2.14 result.
// ----------------------------------------------------------------------------
// Usage:
//   The point channel (point_valid, point_stall) takes point_x, point_y in
//   Q16.16 and noise_seed. The noise channel (noise_valid, noise_stall)
//   returns noise_value in signed Q2.14, one result for each item.
//   An item is taken at a clock edge where valid is high and stall is low.
//   From the accepting edge to noise_valid an item passes four cell
//   stages, four corner stages, a sum stage and the output register, the
//   first of which loads at the accepting edge.
//   Throughput is one item per cycle while point_stall stays low; every
//   stage, including the output register, has its own valid bit, so items
//   keep moving into empty stages while a finished result waits.
//   When the receiver stalls, the full stages hold their items; point_stall
//   rises only when every stage holds an item.
//   Synchronous reset empties the pipeline; no item is in flight after it.
// ----------------------------------------------------------------------------
module simplex_noise_2d (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [31:0]        noise_seed,
  output logic               noise_valid,
  input  logic               noise_stall,
  output logic signed [15:0] noise_value
);
  import snd_pkg::*;

  // Stage valid bits and load enables; a stage loads when it is empty or
  // when the stage after it loads.
  logic [9:0] vld;
  logic [9:0] en;

  always_comb begin
    en[9] = !vld[9] || !noise_stall;
    for (int k = 8; k >= 0; k--) begin
      en[k] = !vld[k] || en[k + 1];
    end
  end

  assign point_stall = !en[0];
  assign noise_valid = vld[9];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= point_valid;
      end
      for (int k = 1; k < 10; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  // Cell stages.
  corner_in_t corner [3];

  snd_cell u_cell (
    .clk        (clk),
    .en         (en[3:0]),
    .point_x    (point_x),
    .point_y    (point_y),
    .noise_seed (noise_seed),
    .corner     (corner)
  );

  // One falloff pipeline per corner.
  logic signed [31:0] term [3];

  for (genvar g = 0; g < 3; g++) begin : g_corner
    snd_corner u_corner (
      .clk  (clk),
      .en   (en[7:4]),
      .cin  (corner[g]),
      .term (term[g])
    );
  end

  // Sum stage: add the three terms and scale by 70.
  logic signed [33:0] sum3;
  logic signed [40:0] sw, p70;
  logic signed [40:0] i_p70;

  assign sum3 = 34'(term[0]) + 34'(term[1]) + 34'(term[2]);
  assign sw   = 41'(sum3);
  assign p70  = (sw <<< 6) + (sw <<< 2) + (sw <<< 1);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      i_p70 <= p70;
    end
  end

  // Output stage: round half up to Q2.14 and saturate.
  logic signed [40:0] rnd;
  logic signed [22:0] q;
  logic signed [15:0] noise_value_next;

  assign rnd = i_p70 + 41'sd131072;
  assign q   = rnd[40:18];

  always_comb begin
    if (q > 23'sd32767) begin
      noise_value_next = 16'sh7FFF;
    end else if (q < -23'sd32768) begin
      noise_value_next = -16'sd32768;
    end else begin
      noise_value_next = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      noise_value <= noise_value_next;
    end
  end

  // Checks on the stage control.
  `include "simplex_noise_2d_assert.svh"

  `SND_ASSERT_SAME(a_idle_out_ready, clk, rst, !noise_valid, !point_stall)
  `SND_ASSERT_SAME(a_stall_from_out, clk, rst, point_stall, noise_valid && noise_stall)
  `SND_ASSERT_NEXT(a_last_fills, clk, rst, vld[8] && !noise_valid, noise_valid)

endmodule

FILE: rtl/snd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_cell: lattice cell, corner offsets and corner hash premix
// Four register stages: skew, cell index, unskew with hash products, and
// corner setup with middle corner choice.
// ----------------------------------------------------------------------------
module snd_cell (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [31:0]        noise_seed,
  output snd_pkg::corner_in_t corner [3]
);
  import snd_pkg::*;

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

  function automatic logic [31:0] rotl17(input logic [31:0] v);
    return {v[14:0], v[31:15]};
  endfunction

  // True when the offset fits a 17-bit signed value.
  function automatic logic fits17(input logic signed [35:0] v);
    return (&v[35:16]) || !(|v[35:16]);
  endfunction

  // Stage A: skew term s = floor((x + y) * F2).
  logic signed [32:0] sxy;
  logic signed [47:0] sxy_w;
  logic signed [47:0] skew_w;
  logic signed [47:0] sprod;
  logic signed [31:0] a_px, a_py;
  logic signed [32:0] a_s;
  logic [31:0]        a_seed;

  assign sxy    = 33'(point_x) + 33'(point_y);
  assign sxy_w  = 48'(sxy);
  assign skew_w = 48'(SKEW_Q15);
  assign sprod  = sxy_w * skew_w;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_px   <= point_x;
      a_py   <= point_y;
      a_s    <= sprod[47:15];
      a_seed <= noise_seed;
    end
  end

  // Stage B: cell index and fractional part of the skewed point.
  logic signed [33:0] sum_x, sum_y;
  logic signed [17:0] b_ci, b_cj;
  logic [15:0]        b_fx, b_fy;
  logic signed [32:0] b_s;
  logic [31:0]        b_seed;

  assign sum_x = 34'(a_px) + 34'(a_s);
  assign sum_y = 34'(a_py) + 34'(a_s);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_ci   <= sum_x[33:16];
      b_cj   <= sum_y[33:16];
      b_fx   <= sum_x[15:0];
      b_fy   <= sum_y[15:0];
      b_s    <= a_s;
      b_seed <= a_seed;
    end
  end

  // Stage C: first corner offset and the index products of the hash.
  logic signed [18:0] cij;
  logic signed [34:0] cij_w, unskew_w, tsk;
  logic signed [34:0] x0, y0;
  logic [31:0]        ci32, cj32;
  logic signed [34:0] c_x0, c_y0;
  logic [31:0]        c_a, c_b, c_seed;

  assign cij      = 19'(b_ci) + 19'(b_cj);
  assign cij_w    = 35'(cij);
  assign unskew_w = 35'(UNSKEW2_Q16);
  assign tsk      = cij_w * unskew_w;
  assign x0       = 35'($signed({1'b0, b_fx})) - 35'(b_s) + tsk;
  assign y0       = 35'($signed({1'b0, b_fy})) - 35'(b_s) + tsk;
  assign ci32     = 32'(b_ci);
  assign cj32     = 32'(b_cj);

  logic [31:0] c_seed_next;
  assign c_seed_next = b_seed;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_x0   <= x0;
      c_y0   <= y0;
      c_a    <= ci32 * HASH_C1;
      c_b    <= cj32 * HASH_C2;
      c_seed <= c_seed_next;
    end
  end

  // Stage D: middle corner choice, offsets of all corners and hash premix.
  logic               di;
  logic signed [35:0] dx [3];
  logic signed [35:0] dy [3];
  logic [31:0]        ha [3];
  logic [31:0]        hb [3];
  logic [31:0]        h0;

  always_comb begin
    di    = c_x0 > c_y0;
    h0    = c_seed + HASH_C0;
    dx[0] = 36'(c_x0);
    dy[0] = 36'(c_y0);
    dx[1] = 36'(c_x0) + (di ? OFS_G1_M1 : OFS_G1);
    dy[1] = 36'(c_y0) + (di ? OFS_G1 : OFS_G1_M1);
    dx[2] = 36'(c_x0) + OFS_G2_M1;
    dy[2] = 36'(c_y0) + OFS_G2_M1;
    // Index + 1 times a constant is the product plus the constant.
    ha[0] = c_a;
    hb[0] = c_b;
    ha[1] = di ? c_a + HASH_C1 : c_a;
    hb[1] = di ? c_b : c_b + HASH_C2;
    ha[2] = c_a + HASH_C1;
    hb[2] = c_b + HASH_C2;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        corner[k].mix  <= rotl17(rotl13(h0 ^ ha[k]) ^ hb[k]);
        corner[k].dx   <= dx[k][16:0];
        corner[k].dy   <= dy[k][16:0];
        corner[k].near <= fits17(dx[k]) && fits17(dy[k]);
      end
    end
  end

endmodule

FILE: rtl/snd_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_corner: contribution of one simplex corner
// Four register stages: hash multiply and squared radius, falloff square
// and gradient dot product, falloff fourth power, and the final product.
// ----------------------------------------------------------------------------
module snd_corner (
  input  logic               clk,
  input  logic [3:0]         en,
  input  snd_pkg::corner_in_t cin,
  output logic signed [31:0] term
);
  import snd_pkg::*;

  function automatic logic signed [15:0] grad_x(input logic [2:0] sel);
    case (sel)
      3'd0:    return 16'sd32767;
      3'd1:    return -16'sd32767;
      3'd2:    return 16'sd0;
      3'd3:    return 16'sd0;
      3'd4:    return 16'sd23170;
      3'd5:    return -16'sd23170;
      3'd6:    return 16'sd23170;
      default: return -16'sd23170;
    endcase
  endfunction

  function automatic logic signed [15:0] grad_y(input logic [2:0] sel);
    case (sel)
      3'd0:    return 16'sd0;
      3'd1:    return 16'sd0;
      3'd2:    return 16'sd32767;
      3'd3:    return -16'sd32767;
      3'd4:    return 16'sd23170;
      3'd5:    return 16'sd23170;
      3'd6:    return -16'sd23170;
      default: return -16'sd23170;
    endcase
  endfunction

  // Stage E: final hash multiply and squared distance.
  logic signed [33:0] dxw, dyw;
  logic signed [33:0] sqx, sqy;
  logic [31:0]        e_h;
  logic [34:0]        e_sq;
  logic signed [16:0] e_dx, e_dy;
  logic               e_near;

  assign dxw = 34'(cin.dx);
  assign dyw = 34'(cin.dy);
  assign sqx = dxw * dxw;
  assign sqy = dyw * dyw;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e_h    <= cin.mix * HASH_C3;
      e_sq   <= 35'(unsigned'(sqx)) + 35'(unsigned'(sqy));
      e_dx   <= cin.dx;
      e_dy   <= cin.dy;
      e_near <= cin.near;
    end
  end

  // Stage F: falloff square and gradient dot product.
  logic [2:0]         sel;
  logic [18:0]        r2;
  logic [15:0]        fu;
  logic [31:0]        fu_w, fsq;
  logic signed [33:0] gxw, gyw, exw, eyw, gsum;
  logic [14:0]        f_f2;
  logic signed [18:0] f_dot;
  logic               f_pos;

  assign sel  = e_h[2:0] ^ e_h[18:16];
  assign r2   = e_sq[34:16];
  assign fu   = 16'(19'd32768 - r2);
  assign fu_w = 32'(fu);
  assign fsq  = fu_w * fu_w;
  assign gxw  = 34'(grad_x(sel));
  assign gyw  = 34'(grad_y(sel));
  assign exw  = 34'(e_dx);
  assign eyw  = 34'(e_dy);
  assign gsum = gxw * exw + gyw * eyw;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f_f2  <= fsq[30:16];
      f_dot <= gsum[33:15];
      f_pos <= e_near && (r2 < 19'd32768);
    end
  end

  // Stage G: falloff fourth power; a corner out of reach gives zero.
  logic [29:0]        f2w, f4sq;
  logic [12:0]        g_f4;
  logic signed [18:0] g_dot;

  assign f2w  = 30'(f_f2);
  assign f4sq = f2w * f2w;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      g_f4  <= f_pos ? f4sq[28:16] : 13'd0;
      g_dot <= f_dot;
    end
  end

  // Stage H: corner term in Q.32.
  logic signed [31:0] f4w, dotw;

  assign f4w  = 32'($signed({1'b0, g_f4}));
  assign dotw = 32'(g_dot);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      term <= f4w * dotw;
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 2D simplex noise block
// Sample points and seeds are queued by an initial block and driven by a
// clocked driver. A clocked monitor compares each noise value with a noise
// value computed in the bench from the same point, oldest first.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        seed;
  } sample_t;

  logic               clk;
  logic               rst;
  logic               point_valid;
  logic               point_stall;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [31:0]        noise_seed;
  logic               noise_valid;
  logic               noise_stall;
  logic signed [15:0] noise_value;

  sample_t            pending_samples[$];
  logic signed [15:0] expected_noise[$];
  int                 error_count;
  int                 cycle_count;
  bit                 stimulus_done;
  bit                 sender_hold;
  int                 send_gap;
  int                 recv_gap;
  int                 long_hold;
  int                 hold_request;

  simplex_noise_2d dut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .noise_seed  (noise_seed),
    .noise_valid (noise_valid),
    .noise_stall (noise_stall),
    .noise_value (noise_value)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor division by a power of two.
  function automatic longint floor_div2(longint v, int n);
    return v >>> n;
  endfunction

  // Rotate-and-multiply hash of one lattice corner.
  function automatic logic [31:0] lattice_hash(longint ci, longint cj, logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] a;
    logic [31:0] b;
    a = ci[31:0];
    b = cj[31:0];
    h = seed + snd_pkg::HASH_C0;
    h ^= a * snd_pkg::HASH_C1;
    h = {h[18:0], h[31:19]};
    h ^= b * snd_pkg::HASH_C2;
    h = {h[14:0], h[31:15]};
    h = h * snd_pkg::HASH_C3;
    h ^= h >> 16;
    return h;
  endfunction

  // Contribution of one corner in Q.32.
  function automatic longint corner_contrib(longint ci, longint cj, longint dx, longint dy,
                                            logic [31:0] seed);
    longint r2;
    longint f;
    longint f2;
    longint f4;
    longint gx;
    longint gy;
    logic [2:0] sel;
    r2 = floor_div2(dx * dx + dy * dy, 16);
    f = 32768 - r2;
    if (f <= 0) return 0;
    f2 = floor_div2(f * f, 16);
    f4 = floor_div2(f2 * f2, 16);
    sel = 3'(lattice_hash(ci, cj, seed));
    case (sel)
      3'd0: begin gx = 32767; gy = 0; end
      3'd1: begin gx = -32767; gy = 0; end
      3'd2: begin gx = 0; gy = 32767; end
      3'd3: begin gx = 0; gy = -32767; end
      3'd4: begin gx = 23170; gy = 23170; end
      3'd5: begin gx = -23170; gy = 23170; end
      3'd6: begin gx = 23170; gy = -23170; end
      default: begin gx = -23170; gy = -23170; end
    endcase
    return f4 * floor_div2(gx * dx + gy * dy, 15);
  endfunction

  // Noise value of one sample point, Q2.14 saturated.
  function automatic logic signed [15:0] noise_at(sample_t s);
    longint px;
    longint py;
    longint sk;
    longint ci;
    longint cj;
    longint t;
    longint x0;
    longint y0;
    longint g1;
    longint di;
    longint dj;
    longint sum;
    longint v;
    px = s.px;
    py = s.py;
    g1 = 13850;
    sk = floor_div2((px + py) * 11994, 15);
    ci = floor_div2(px + sk, 16);
    cj = floor_div2(py + sk, 16);
    t = (ci + cj) * 13850;
    x0 = px - ci * 65536 + t;
    y0 = py - cj * 65536 + t;
    di = (x0 > y0) ? 1 : 0;
    dj = 1 - di;
    sum = corner_contrib(ci, cj, x0, y0, s.seed);
    sum += corner_contrib(ci + di, cj + dj, x0 - di * 65536 + g1, y0 - dj * 65536 + g1,
                          s.seed);
    sum += corner_contrib(ci + 1, cj + 1, x0 - 65536 + 2 * g1, y0 - 65536 + 2 * g1, s.seed);
    v = floor_div2(sum * 70 + (64'sd1 <<< 17), 18);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random coordinate: small, mid or anywhere in range.
  function automatic logic [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    if (r < 8) return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    return $urandom;
  endfunction

  // Sender: offers the next queued item, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(point_valid && point_stall)) begin
      sample_t s;
      if (point_valid) expected_noise.push_back(noise_at({point_x, point_y, noise_seed}));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        point_valid <= 1'b0;
      end else if (pending_samples.size() > 0 && !sender_hold) begin
        s = pending_samples.pop_front();
        point_valid <= 1'b1;
        point_x <= s.px;
        point_y <= s.py;
        noise_seed <= s.seed;
        send_gap <= pick_gap();
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      noise_stall <= 1'b0;
      recv_gap <= 0;
      long_hold <= 0;
    end else begin
      if (hold_request > 0 && long_hold == 0) begin
        long_hold <= hold_request;
        hold_request <= 0;
        noise_stall <= 1'b1;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        noise_stall <= (long_hold > 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        noise_stall <= 1'b1;
      end else begin
        recv_gap <= pick_gap();
        noise_stall <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted noise value with the oldest expectation.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && noise_valid && !noise_stall) begin
      if (expected_noise.size() == 0) begin
        $error("noise_value: unexpected result %0d", noise_value);
        error_count++;
      end else begin
        want = expected_noise.pop_front();
        if (noise_value !== want) begin
          $error("noise_value: expected %0d, actual %0d", want, noise_value);
          error_count++;
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic queue_sample(logic [31:0] x, logic [31:0] y, logic [31:0] seed);
    pending_samples.push_back({x, y, seed});
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || point_valid || expected_noise.size() > 0)
      @(posedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    error_count = 0;
    cycle_count = 0;
    stimulus_done = 0;
    sender_hold = 0;
    hold_request = 0;
    rst = 1'b1;
    point_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    noise_seed = '0;
    noise_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: origin, extremes, negative cells, corners and all-ones seed.
    queue_sample(32'h0, 32'h0, 32'h0);
    queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_sample(32'h8000_0000, 32'h8000_0000, 32'h0);
    queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    queue_sample(32'h0001_8000, 32'h0000_4000, 32'h5A5A_5A5A);
    queue_sample(32'h0000_4000, 32'h0001_8000, 32'h5A5A_5A5A);
    queue_sample(32'hFFFE_8000, 32'hFFFD_0000, 32'h0000_0001);
    queue_sample(32'h0000_8000, 32'h0000_8000, 32'h8000_0000);
    queue_sample(32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_sample(32'h0000_0000, 32'h0001_0000, 32'h0);
    for (int k = 0; k < 12; k++)
      queue_sample($urandom_range(0, 32'h3_0000), $urandom_range(0, 32'h3_0000), k);

    // Once every expected result has come, the sender is held and then released.
    wait_drained();
    sender_hold = 1;
    repeat (10) @(posedge clk);
    sender_hold = 0;

    // Random part, with one long receiver hold-off while items keep coming.
    for (int n = 0; n < 1300; n++) begin
      queue_sample(pick_coord(), pick_coord(), $urandom);
      if (n == 300) hold_request = 120;
      if (n % 100 == 0) @(posedge clk);
    end
    wait_drained();
    repeat (30) @(posedge clk);
    if (error_count == 0 && expected_noise.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
